/* sv/sis_pkg.sv */
// package: shared constants, word types and control structs of the insertion sorter
`default_nettype none

package sis_pkg;

    // number of cells in the chain
    localparam int unsigned CAPACITY   = 64;
    // element width
    localparam int unsigned DATA_WIDTH = 32;

    // input word
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         last;
    } sis_item_t;

    // output word
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value_res;
        logic                         last_res;
        logic                         overflow;
    } sis_result_t;

    // what one cell shows its neighbors
    typedef struct packed {
        logic                         valid;
        logic                         keep;
        logic signed [DATA_WIDTH-1:0] value;
    } sis_link_t;

    // chain-wide commands
    typedef struct packed {
        logic insert;
        logic shift;
    } sis_ctrl_t;

    // sequencer states
    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } sis_state_t;

endpackage

`default_nettype wire

/* sv/sis_cell.sv */
// one cell of the sorting chain: holds a single element and its valid bit
`default_nettype none

module sis_cell
    import sis_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire sis_ctrl_t                    ctrl,
    input  wire logic signed [DATA_WIDTH-1:0] new_value,
    input  wire sis_link_t                    left,
    input  wire sis_link_t                    right,
    output      sis_link_t                    link
);

    logic                         valid_reg;
    logic                         valid_next;
    logic signed [DATA_WIDTH-1:0] value_reg;
    logic signed [DATA_WIDTH-1:0] value_next;
    logic                         keep;

    // stay put when holding a value not greater than the new one (keeps equals ahead)
    assign keep = valid_reg && (value_reg <= new_value);

    // next contents: take new value, take left neighbor, or take right neighbor on drain
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.insert && !keep)
        begin
            if (left.keep)
            begin
                valid_next = 1'b1;
                value_next = new_value;
            end
            else
            begin
                valid_next = left.valid;
                value_next = left.value;
            end
        end
        else if (ctrl.shift)
        begin
            valid_next = right.valid;
            value_next = right.value;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // element storage
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.valid = valid_reg;
    assign link.keep  = keep;
    assign link.value = value_reg;

endmodule

`default_nettype wire

/* sv/stable_insertion_sorter_core.sv */
// Stable ascending insertion sorter built as a chain of compare-and-shift cells.
//
// Input channel item_valid / item_ready / item carries one signed element per
// word, item.last closes the set. Each element is inserted in parallel:
// every cell compares against it at once and the cells above the insertion
// point move up by one. Equal values land behind earlier ones.
// While a set is filling, one word is taken every cycle.
// After the word flagged last, the chain drains toward cell 0, one element
// per cycle while the receiver takes them, through an output register onto
// result_valid / result_ready / result. Item_ready stays low during the drain
// and returns once the final result has been loaded into the output register.
// Words that arrive while all cells are full are dropped and every result of
// that set carries overflow. A stalled receiver holds the output register and
// freezes the drain.
// Reset empties all cells and the output register; no clearing pass is needed.
`default_nettype none

module stable_insertion_sorter_core
    import sis_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output      logic        item_ready,
    input  wire sis_item_t   item,
    output      logic        result_valid,
    input  wire logic        result_ready,
    output      sis_result_t result
);

    sis_state_t  state_reg;
    sis_state_t  state_next;
    logic        drop_reg;
    logic        drop_next;
    logic        result_valid_reg;
    logic        result_valid_next;
    sis_result_t result_reg;
    sis_result_t result_next;
    sis_ctrl_t   ctrl;
    logic        accept;
    logic        full;
    logic        load;
    logic        final_word;

    sis_link_t   links   [CAPACITY];
    sis_link_t   lefts   [CAPACITY];
    sis_link_t   rights  [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;

    // chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign lefts[i] = '{valid: 1'b0, keep: 1'b1, value: '0};
        end
        else
        begin : g_body
            assign lefts[i] = links[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign rights[i] = '{valid: 1'b0, keep: 1'b0, value: '0};
        end
        else
        begin : g_inner
            assign rights[i] = links[i+1];
        end

        sis_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .new_value (item.value),
            .left      (lefts[i]),
            .right     (rights[i]),
            .link      (links[i])
        );

        assign cell_valid[i] = links[i].valid;
    end

    // handshake and chain commands
    assign item_ready  = (state_reg == ST_FILL);
    assign accept      = item_valid && item_ready;
    assign full        = cell_valid[CAPACITY-1];
    assign load        = (state_reg == ST_DRAIN) && (!result_valid_reg || result_ready);
    assign final_word  = !cell_valid[1];
    assign ctrl.insert = accept && !full;
    assign ctrl.shift  = load;

    // sequencer, drop flag and output register
    always_comb
    begin
        state_next        = state_reg;
        drop_next         = drop_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_FILL:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    if (item.last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (load)
                begin
                    result_valid_next     = 1'b1;
                    result_next.value_res = links[0].value;
                    result_next.last_res  = final_word;
                    result_next.overflow  = drop_reg;
                    if (final_word)
                    begin
                        state_next = ST_FILL;
                        drop_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_FILL;
            drop_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            drop_reg         <= drop_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    // insertion and drain never overlap
    a_no_insert_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.insert && ctrl.shift))
        else $error("insert and shift in the same cycle");

    // occupied cells form a prefix: a full chain has cell 0 filled
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[CAPACITY-1] |-> cell_valid[0])
        else $error("chain has a hole at cell 0");

    // a drain always has an element in cell 0
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> cell_valid[0])
        else $error("drain with empty chain");

    // loading the final word ends the set and clears the drop flag
    a_final_ends_set: assert property (@(posedge clk) disable iff (!rst_n)
        (load && final_word) |=> (state_reg == ST_FILL) && !drop_reg && (cell_valid == '0))
        else $error("set not closed after final word");
`endif

endmodule

`default_nettype wire
